[design/aat_pkg.sv]
// ---------------------------------------------------------------------------
// aat_pkg: shared constants for the box affine transform
// Register map, register reset values and packed field widths.
// ---------------------------------------------------------------------------
package aat_pkg;

   // packed register layout: three 16-bit fields in 48 bits
   localparam int REG_W    = 48;
   localparam int FIELD_W  = 16;
   localparam int NUM_AXES = 3;

   // configuration port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 2;

   typedef logic [REG_IDX_W-1:0] reg_idx_type;
   typedef logic [REG_W-1:0]     reg_val_type;

   // register indexes
   localparam reg_idx_type REG_ROW_0 = 2'd0;
   localparam reg_idx_type REG_ROW_1 = 2'd1;
   localparam reg_idx_type REG_ROW_2 = 2'd2;
   localparam reg_idx_type REG_TRANS = 2'd3;

   // reset values: identity matrix, zero translation
   localparam reg_val_type ROW_0_RESET = 48'h0000_0000_1000;
   localparam reg_val_type ROW_1_RESET = 48'h0000_1000_0000;
   localparam reg_val_type ROW_2_RESET = 48'h1000_0000_0000;
   localparam reg_val_type TRANS_RESET = 48'h0000_0000_0000;

endpackage

[design/aabb_affine_transform_top.sv]
// ---------------------------------------------------------------------------
// aabb_affine_transform_top: affine transform of an axis-aligned box
// Maps a box given as center and half extent through a configured affine
// transform and returns the tight enclosing box, rounded and saturated.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* channel takes one box (center and half extent per axis) per
//    transaction; rsp_* channel returns the transformed box, one transaction
//    per request, in order.
//  - csr_* is an APB-style port with four 48-bit registers at byte
//    addresses 0, 8, 16, 24: matrix rows 0..2 and the translation row.
//    Write them only while no transaction is in flight.
//  - A request is accepted into the input register; the products, sums,
//    rounding and saturation then feed the result register, which drives
//    rsp_valid and the response. Throughput is one box per cycle while
//    rsp_ready stays high, set by the eighteen parallel multipliers between
//    those two registers.
//  - The center uses center' = t + sum(c * m), the half extent uses
//    half' = sum(h * |m|); both are exact until the final rounding.
//  - A stalled response holds in the result register while one more
//    request is taken into the input register; beyond that req_ready
//    drops until rsp_ready returns.
//  - Reset empties both stages and loads the identity transform.
// ---------------------------------------------------------------------------
module aabb_affine_transform_top #(
   parameter int COORD_WIDTH    = 16,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [COORD_WIDTH-1:0]      req_center_x,
   input  logic signed [COORD_WIDTH-1:0]      req_center_y,
   input  logic signed [COORD_WIDTH-1:0]      req_center_z,
   input  logic        [COORD_WIDTH-2:0]      req_half_x,
   input  logic        [COORD_WIDTH-2:0]      req_half_y,
   input  logic        [COORD_WIDTH-2:0]      req_half_z,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [COORD_WIDTH-1:0]      rsp_new_center_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_new_center_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_new_center_z,
   output logic        [COORD_WIDTH-2:0]      rsp_new_half_x,
   output logic        [COORD_WIDTH-2:0]      rsp_new_half_y,
   output logic        [COORD_WIDTH-2:0]      rsp_new_half_z,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [aat_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [aat_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [aat_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import aat_pkg::*;

   localparam int W      = COORD_WIDTH;
   localparam int F      = COEF_FRAC_BITS;
   localparam int WF_MAX = (W > F) ? W : F;
   localparam int PROD_W = W + FIELD_W;
   localparam int ACC_W  = WF_MAX + FIELD_W + 3;
   localparam int ABS_W  = FIELD_W + 1;
   localparam logic signed [ACC_W-1:0] CMAX = ACC_W'((64'(1) << (W - 1)) - 64'(1));
   localparam logic signed [ACC_W-1:0] CMIN = -CMAX - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (F - 1);

   // configuration registers
   reg_val_type row_ff [NUM_AXES];
   reg_val_type trans_ff;
   reg_idx_type csr_idx;
   logic        csr_wr;

   // pipeline registers
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [W-1:0]     s1_center_ff [NUM_AXES];
   logic        [W-2:0]     s1_half_ff   [NUM_AXES];
   logic                    s2_valid_ff, s2_valid_in;
   logic signed [W-1:0]     s2_center_ff [NUM_AXES];
   logic signed [W-1:0]     s2_center_in [NUM_AXES];
   logic        [W-2:0]     s2_half_ff   [NUM_AXES];
   logic        [W-2:0]     s2_half_in   [NUM_AXES];

   logic s2_free;
   logic s1_move;
   logic req_take;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1 -: REG_IDX_W];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= ROW_0_RESET;
         row_ff[1] <= ROW_1_RESET;
         row_ff[2] <= ROW_2_RESET;
         trans_ff  <= TRANS_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ROW_0: row_ff[0] <= csr_pwdata[REG_W-1:0];
            REG_ROW_1: row_ff[1] <= csr_pwdata[REG_W-1:0];
            REG_ROW_2: row_ff[2] <= csr_pwdata[REG_W-1:0];
            REG_TRANS: trans_ff  <= csr_pwdata[REG_W-1:0];
            default:   trans_ff  <= trans_ff;
         endcase
      end
   end

   // read back the addressed register
   always_comb begin
      unique case (csr_idx)
         REG_ROW_0: csr_prdata = CSR_DATA_W'(row_ff[0]);
         REG_ROW_1: csr_prdata = CSR_DATA_W'(row_ff[1]);
         REG_ROW_2: csr_prdata = CSR_DATA_W'(row_ff[2]);
         REG_TRANS: csr_prdata = CSR_DATA_W'(trans_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   assign s2_free   = !s2_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in = req_take || (s1_valid_ff && !s2_free);
   assign s2_valid_in = s1_move || (s2_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // capture the request
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_center_ff[0] <= req_center_x;
         s1_center_ff[1] <= req_center_y;
         s1_center_ff[2] <= req_center_z;
         s1_half_ff[0]   <= req_half_x;
         s1_half_ff[1]   <= req_half_y;
         s1_half_ff[2]   <= req_half_z;
      end
   end

   // ---------------- transform datapath ----------------
   // center' = t + sum c_i*m[i][j], half' = sum h_i*|m[i][j]|, then round
   always_comb begin
      logic signed [FIELD_W-1:0] coef;
      logic        [ABS_W-1:0]   coef_abs;
      logic signed [PROD_W-1:0]  cprod;
      logic        [PROD_W-1:0]  hprod;
      logic signed [FIELD_W-1:0] tr;
      logic signed [ACC_W-1:0]   csum;
      logic signed [ACC_W-1:0]   hsum;
      logic signed [ACC_W-1:0]   cshift;
      logic signed [ACC_W-1:0]   hshift;
      for (int j = 0; j < NUM_AXES; j++) begin
         tr   = trans_ff[FIELD_W*j +: FIELD_W];
         csum = ACC_W'(tr) <<< F;
         hsum = '0;
         for (int i = 0; i < NUM_AXES; i++) begin
            coef     = row_ff[i][FIELD_W*j +: FIELD_W];
            coef_abs = coef[FIELD_W-1] ? (ABS_W'(~coef) + ABS_W'(1)) : ABS_W'(coef);
            cprod    = coef * s1_center_ff[i];
            hprod    = coef_abs * s1_half_ff[i];
            csum     = csum + ACC_W'(cprod);
            hsum     = hsum + $signed(ACC_W'(hprod));
         end
         // round to nearest, ties up
         cshift = (csum + HALF_LSB) >>> F;
         hshift = (hsum + HALF_LSB) >>> F;
         // saturate
         priority if (cshift > CMAX) begin
            s2_center_in[j] = W'(CMAX);
         end else if (cshift < CMIN) begin
            s2_center_in[j] = W'(CMIN);
         end else begin
            s2_center_in[j] = W'(cshift);
         end
         priority if (hshift > CMAX) begin
            s2_half_in[j] = (W-1)'(CMAX);
         end else if (hshift < ACC_W'(0)) begin
            s2_half_in[j] = '0;
         end else begin
            s2_half_in[j] = (W-1)'(hshift);
         end
      end
   end

   // load the result register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_center_ff <= s2_center_in;
         s2_half_ff   <= s2_half_in;
      end
   end

   assign rsp_valid        = s2_valid_ff;
   assign rsp_new_center_x = s2_center_ff[0];
   assign rsp_new_center_y = s2_center_ff[1];
   assign rsp_new_center_z = s2_center_ff[2];
   assign rsp_new_half_x   = s2_half_ff[0];
   assign rsp_new_half_y   = s2_half_ff[1];
   assign rsp_new_half_z   = s2_half_ff[2];

   // ---------------- assertions ----------------
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid)
      else $error("pipeline not empty after reset");

   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted request did not reach input register");

   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_free |=> rsp_valid)
      else $error("input register item did not reach result register");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_free |=> s1_valid_ff && $stable(s1_center_ff[0])
         && $stable(s1_half_ff[0]))
      else $error("blocked input register item changed or was lost");

endmodule
